// ===== rtl/pes_pkg.sv =====
package pes_pkg;

  typedef logic [23:0] pixel_t;

  localparam int CFG_DW = 16;
  localparam int CFG_IW = 3;

  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ORTHO_WEIGHT = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MAIN_WEIGHT  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_RED_WEIGHT   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_GREEN_WEIGHT = 3'd5;
  localparam logic [CFG_IW-1:0] REG_BLUE_WEIGHT  = 3'd6;

  // result kinds, in emission order
  localparam logic [1:0] KIND_H_ABOVE = 2'd0;
  localparam logic [1:0] KIND_V_LEFT  = 2'd1;
  localparam logic [1:0] KIND_V_RIGHT = 2'd2;
  localparam logic [1:0] KIND_H_BELOW = 2'd3;

  localparam int SUM_W  = 30;
  localparam int ROOT_W = 15;
  localparam int PROD_W = 28;

endpackage

// ===== rtl/pixel_edge_strength_unit.sv =====
// channel | direction | ports                                        | word accepted when
// in      | input     | in_valid, in_stall, in_red/green/blue        | in_valid && !in_stall
// out     | output    | out_valid, out_stall, out_direction, ...     | out_valid && !out_stall
// cfg     | input     | cfg_we, cfg_index, cfg_wdata                 | cfg_we
// A pixel that yields no edge goes from accept straight to done. Otherwise the unit reads
// the line buffers, then per edge computes 3 saliences, each on the multiplier and then the
// square root, combines them and outputs the edge word, waiting while out_stall is high;
// then it closes the pixel. The shared 12x16 multiplier and the two-bits-per-cycle square
// root set its pace. Synchronous reset clears control and configuration; line buffers
// start undefined. in_stall is high in reset and from accept until done.
module pixel_edge_strength_unit
  import pes_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_direction,
  output logic [9:0]          out_edge_column,
  output logic [15:0]         out_edge_row,
  output logic [19:0]         out_strength,
  output logic                out_last_of_run,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_wdata
);

  localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int DEPTH = 3 * MAX_WIDTH;
  localparam int AW = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_COMB = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [10:0] width_r;
  logic [15:0] height_r;
  logic [11:0] ow_r, mw_r, rw_r, gw_r, bw_r;

  logic [2:0]        state_r;
  logic [2:0]        step_r;
  logic [1:0]        pair_r;
  logic [1:0]        kind_r;
  logic [3:0]        flags_r;
  logic [XW-1:0]     col_r, x_r;
  logic [15:0]       row_r, y_r;
  logic              xl_r, yl_r;
  logic [1:0]        bank_r;
  pixel_t            p_r, prev_r;
  pixel_t            rd_r [6];
  pixel_t            rd_data_r;
  pixel_t            mem [DEPTH];
  logic [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  v_r;
  logic [SUM_W-1:0]  r_r;
  logic [SUM_W-1:0]  bit_r;
  logic [ROOT_W-1:0] sal_r [3];
  logic [19:0]       strength_r;

  logic [15:0] w_eff, h_eff, wl, hl, x_calc, y_calc;
  logic [1:0]  mid_bank, up_bank;
  logic [AW-1:0] cur_off, mid_off, up_off, rd_addr, rd_off;
  pixel_t op_a, op_b;
  logic [7:0]  ch_a, ch_b, dabs;
  logic [8:0]  dsub;
  logic [11:0] mul_a, wsel;
  logic [15:0] mul_b;
  logic [ROOT_W-1:0] sal_min;
  logic [SUM_W:0] root_t;
  logic [3:0]  flags_next;
  logic [1:0]  kind_next;
  logic        x_ge2;

  always_comb begin
    w_eff = {5'd0, width_r};
    if (w_eff < 16'd2) w_eff = 16'd2;
    if (w_eff > 16'(MAX_WIDTH)) w_eff = 16'(MAX_WIDTH);
    h_eff = (height_r == 16'd0) ? 16'd1 : height_r;
    wl = w_eff - 16'd1;
    hl = h_eff - 16'd1;
    x_calc = (16'(col_r) > wl) ? wl : 16'(col_r);
    y_calc = (row_r > hl) ? hl : row_r;
  end

  function automatic logic [AW-1:0] bank_off(input logic [1:0] b);
    case (b)
      2'd0: bank_off = '0;
      2'd1: bank_off = AW'(MAX_WIDTH);
      default: bank_off = AW'(2 * MAX_WIDTH);
    endcase
  endfunction

  assign mid_bank = (bank_r == 2'd0) ? 2'd2 : bank_r - 2'd1;
  assign up_bank  = (mid_bank == 2'd0) ? 2'd2 : mid_bank - 2'd1;
  assign cur_off  = bank_off(bank_r);
  assign mid_off  = bank_off(mid_bank);
  assign up_off   = bank_off(up_bank);
  assign x_ge2    = 16'(x_r) >= 16'd2;

  // read order: above-left, above, middle far-left, middle left, middle, current far-left
  always_comb begin
    rd_off = (y_r >= 16'd2) ? up_off : mid_off;
    case (step_r)
      3'd0: rd_addr = rd_off + AW'(x_r) - AW'(1);
      3'd1: rd_addr = rd_off + AW'(x_r);
      3'd2: rd_addr = mid_off + AW'(x_r) - (x_ge2 ? AW'(2) : AW'(1));
      3'd3: rd_addr = mid_off + AW'(x_r) - AW'(1);
      3'd4: rd_addr = mid_off + AW'(x_r);
      default: rd_addr = cur_off + AW'(x_r) - AW'(2);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst_n && state_r == S_IDLE && in_valid) begin
      mem[cur_off + AW'(x_calc)] <= {in_blue, in_green, in_red};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    op_a = p_r;
    op_b = prev_r;
    case (kind_r)
      KIND_H_ABOVE: begin
        case (pair_r)
          2'd0: begin op_a = rd_r[0]; op_b = prev_r; end
          2'd1: begin op_a = rd_r[1]; op_b = p_r; end
          default: begin op_a = rd_r[3]; op_b = rd_r[4]; end
        endcase
      end
      KIND_V_LEFT: begin
        case (pair_r)
          2'd0: begin op_a = p_r; op_b = x_ge2 ? rd_r[5] : prev_r; end
          2'd1: begin op_a = rd_r[4]; op_b = rd_r[2]; end
          default: begin op_a = rd_r[3]; op_b = prev_r; end
        endcase
      end
      KIND_V_RIGHT: begin
        case (pair_r)
          2'd0: begin op_a = p_r; op_b = prev_r; end
          2'd1: begin op_a = rd_r[4]; op_b = rd_r[3]; end
          default: begin op_a = rd_r[4]; op_b = p_r; end
        endcase
      end
      default: begin
        case (pair_r)
          2'd0: begin op_a = (y_r >= 16'd1) ? rd_r[3] : prev_r; op_b = prev_r; end
          2'd1: begin op_a = (y_r >= 16'd1) ? rd_r[4] : p_r; op_b = p_r; end
          default: begin op_a = prev_r; op_b = p_r; end
        endcase
      end
    endcase
  end

  always_comb begin
    case (step_r[2:1])
      2'd0: begin ch_a = op_a[7:0];   ch_b = op_b[7:0];   wsel = rw_r; end
      2'd1: begin ch_a = op_a[15:8];  ch_b = op_b[15:8];  wsel = gw_r; end
      default: begin ch_a = op_a[23:16]; ch_b = op_b[23:16]; wsel = bw_r; end
    endcase
    dsub = {1'b0, ch_a} - {1'b0, ch_b};
    dabs = dsub[8] ? 8'(-dsub) : dsub[7:0];
    sal_min = (sal_r[0] < sal_r[1]) ? sal_r[0] : sal_r[1];
    if (state_r == S_COMB) begin
      mul_a = (step_r == 3'd0) ? ow_r : mw_r;
      mul_b = {1'b0, (step_r == 3'd0) ? sal_min : sal_r[2]};
    end else if (step_r[0]) begin
      mul_a = wsel;
      mul_b = prod_r[15:0];
    end else begin
      mul_a = {4'd0, dabs};
      mul_b = {8'd0, dabs};
    end
    root_t = {1'b0, r_r} + {1'b0, bit_r};
    flags_next = flags_r & ~(4'b0001 << kind_r);
    if (flags_next[0]) kind_next = KIND_H_ABOVE;
    else if (flags_next[1]) kind_next = KIND_V_LEFT;
    else if (flags_next[2]) kind_next = KIND_V_RIGHT;
    else kind_next = KIND_H_BELOW;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 16'd1;
      ow_r <= 12'd256;
      mw_r <= 12'd256;
      rw_r <= 12'd128;
      gw_r <= 12'd128;
      bw_r <= 12'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[10:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        REG_ORTHO_WEIGHT: ow_r <= cfg_wdata[11:0];
        REG_MAIN_WEIGHT:  mw_r <= cfg_wdata[11:0];
        REG_RED_WEIGHT:   rw_r <= cfg_wdata[11:0];
        REG_GREEN_WEIGHT: gw_r <= cfg_wdata[11:0];
        REG_BLUE_WEIGHT:  bw_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a * mul_b);
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      pair_r  <= '0;
      kind_r  <= '0;
      flags_r <= '0;
      col_r   <= '0;
      row_r   <= '0;
      bank_r  <= '0;
      prev_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            p_r   <= {in_blue, in_green, in_red};
            x_r   <= XW'(x_calc);
            y_r   <= y_calc;
            xl_r  <= x_calc == wl;
            yl_r  <= y_calc == hl;
            flags_r <= {x_calc != 16'd0 && y_calc == hl,
                        x_calc != 16'd0 && y_calc != 16'd0 && x_calc == wl,
                        x_calc != 16'd0 && y_calc != 16'd0,
                        x_calc != 16'd0 && y_calc != 16'd0};
            step_r  <= '0;
            state_r <= (x_calc != 16'd0 && (y_calc != 16'd0 || y_calc == hl)) ?
                       S_READ : S_DONE;
          end
        end
        S_READ: begin
          if (step_r != 3'd0) rd_r[step_r - 3'd1] <= rd_data_r;
          if (step_r == 3'd6) begin
            kind_r  <= flags_r[0] ? KIND_H_ABOVE : KIND_H_BELOW;
            pair_r  <= '0;
            step_r  <= '0;
            sum_r   <= '0;
            state_r <= S_MUL;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_MUL: begin
          if (step_r == 3'd2 || step_r == 3'd4) sum_r <= sum_r + SUM_W'(prod_r);
          if (step_r == 3'd6) begin
            v_r     <= sum_r + SUM_W'(prod_r);
            r_r     <= '0;
            bit_r   <= SUM_W'(1) << (SUM_W - 2);
            state_r <= S_ROOT;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_ROOT: begin
          if ({1'b0, v_r} >= root_t) begin
            v_r <= v_r - root_t[SUM_W-1:0];
            r_r <= (r_r >> 1) + bit_r;
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == SUM_W'(1)) begin
            sal_r[pair_r] <= ({1'b0, v_r} >= root_t) ?
                             ROOT_W'((r_r >> 1) + bit_r) : ROOT_W'(r_r >> 1);
            step_r <= '0;
            sum_r  <= '0;
            if (pair_r == 2'd2) begin
              state_r <= S_COMB;
            end else begin
              pair_r  <= pair_r + 2'd1;
              state_r <= S_MUL;
            end
          end
        end
        S_COMB: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd1) sum_r <= SUM_W'(prod_r);
          if (step_r == 3'd2) begin
            strength_r <= 20'((sum_r + SUM_W'(prod_r)) >> 8);
            state_r    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            flags_r <= flags_next;
            if (flags_next != 4'd0) begin
              kind_r  <= kind_next;
              pair_r  <= '0;
              step_r  <= '0;
              sum_r   <= '0;
              state_r <= S_MUL;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          prev_r  <= p_r;
          if (xl_r) begin
            col_r  <= '0;
            bank_r <= (bank_r == 2'd2) ? 2'd0 : bank_r + 2'd1;
            row_r  <= yl_r ? 16'd0 : y_r + 16'd1;
          end else begin
            col_r <= x_r + XW'(1);
            row_r <= y_r;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall        = !rst_n || state_r != S_IDLE;
  assign out_valid       = state_r == S_OUT;
  assign out_direction   = kind_r == KIND_V_LEFT || kind_r == KIND_V_RIGHT;
  assign out_edge_column = (kind_r == KIND_V_LEFT) ? 10'(x_r - XW'(1)) : 10'(x_r);
  assign out_edge_row    = (kind_r == KIND_H_ABOVE) ? y_r - 16'd1 : y_r;
  assign out_strength    = strength_r;
  assign out_last_of_run = flags_next == 4'd0;

endmodule

// ===== tb/sv/pixel_edge_strength_unit_tb.sv =====
`timescale 1ns / 100ps

module pixel_edge_strength_unit_tb
  import pes_pkg::*;
();

  localparam int LINE_DEPTH = 1024;
  localparam logic DIR_H = 1'b0;
  localparam logic DIR_V = 1'b1;
  localparam int PIX_RANDOM = 0;
  localparam int PIX_SMOOTH = 1;
  localparam int PIX_EXTREME = 2;

  typedef struct packed {
    logic        dir;
    logic [9:0]  col;
    logic [15:0] row;
    logic [19:0] str;
    logic        last;
  } edge_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_direction;
  logic [9:0] out_edge_column;
  logic [15:0] out_edge_row;
  logic [19:0] out_strength;
  logic out_last_of_run;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  pixel_edge_strength_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_direction(out_direction), .out_edge_column(out_edge_column),
    .out_edge_row(out_edge_row), .out_strength(out_strength),
    .out_last_of_run(out_last_of_run),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  logic [23:0] pixel_q[$];
  edge_word_t edge_q[$];
  int unsigned err_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int rx_hold = 0;
  logic [23:0] last_gen = 24'h808080;

  // shadow of the block
  int unsigned cfg_regs[7] = '{1024, 1, 256, 256, 128, 128, 128};
  logic [23:0] up_line[LINE_DEPTH];
  logic [23:0] mid_line[LINE_DEPTH];
  logic [23:0] cur_line[LINE_DEPTH];
  logic [23:0] prev_pix = '0;
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;

  function automatic int unsigned int_sqrt(int unsigned v);
    int unsigned r;
    int unsigned b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int unsigned salience(logic [23:0] a, logic [23:0] b);
    int unsigned sum;
    int d;
    sum = 0;
    for (int c = 0; c < 3; c++) begin
      d = int'(a[8*c +: 8]) - int'(b[8*c +: 8]);
      sum += cfg_regs[REG_RED_WEIGHT + c] * int'(d * d);
    end
    return int_sqrt(sum);
  endfunction

  function automatic logic [19:0] edge_strength(int unsigned s1, int unsigned s2,
                                                int unsigned sm);
    longint unsigned m;
    longint unsigned t;
    m = (s1 < s2) ? s1 : s2;
    t = (longint'(cfg_regs[REG_ORTHO_WEIGHT]) * m + longint'(cfg_regs[REG_MAIN_WEIGHT]) * sm) >> 8;
    return (t > 64'hFFFFF) ? 20'hFFFFF : t[19:0];
  endfunction

  function automatic int unsigned eff_width();
    int unsigned w;
    w = cfg_regs[REG_IMAGE_WIDTH];
    if (w < 2) w = 2;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (cfg_regs[REG_IMAGE_HEIGHT] < 1) ? 1 : cfg_regs[REG_IMAGE_HEIGHT];
  endfunction

  function automatic int unsigned pixels_left();
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    w = eff_width();
    h = eff_height();
    if (col_cnt == 0 && row_cnt == 0) return 0;
    x = (col_cnt > w - 1) ? w - 1 : col_cnt;
    y = (row_cnt > h - 1) ? h - 1 : row_cnt;
    return (w - x) + (h - 1 - y) * w;
  endfunction

  task automatic predict_edges(input logic [23:0] p);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    logic [23:0] ua;
    logic [23:0] ub;
    logic [23:0] lc;
    logic [23:0] lm;
    edge_word_t res[$];
    edge_word_t e;
    w = eff_width();
    h = eff_height();
    x = (col_cnt > w - 1) ? w - 1 : col_cnt;
    y = (row_cnt > h - 1) ? h - 1 : row_cnt;
    e = '0;
    if (x >= 1) begin
      if (y >= 1) begin
        ua = (y >= 2) ? up_line[x-1] : mid_line[x-1];
        ub = (y >= 2) ? up_line[x] : mid_line[x];
        lc = (x >= 2) ? cur_line[x-2] : prev_pix;
        lm = (x >= 2) ? mid_line[x-2] : mid_line[x-1];
        e.dir = DIR_H; e.col = 10'(x); e.row = 16'(y - 1);
        e.str = edge_strength(salience(ua, prev_pix), salience(ub, p),
                              salience(mid_line[x-1], mid_line[x]));
        res.insert(res.size(), e);
        e.dir = DIR_V; e.col = 10'(x - 1); e.row = 16'(y);
        e.str = edge_strength(salience(p, lc), salience(mid_line[x], lm),
                              salience(mid_line[x-1], prev_pix));
        res.insert(res.size(), e);
        if (x == w - 1) begin
          e.dir = DIR_V; e.col = 10'(x); e.row = 16'(y);
          e.str = edge_strength(salience(p, prev_pix), salience(mid_line[x], mid_line[x-1]),
                                salience(mid_line[x], p));
          res.insert(res.size(), e);
        end
      end
      if (y == h - 1) begin
        ua = (y >= 1) ? mid_line[x-1] : prev_pix;
        ub = (y >= 1) ? mid_line[x] : p;
        e.dir = DIR_H; e.col = 10'(x); e.row = 16'(y);
        e.str = edge_strength(salience(ua, prev_pix), salience(ub, p), salience(prev_pix, p));
        res.insert(res.size(), e);
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) edge_q.insert(edge_q.size(), res[i]);
    cur_line[x] = p;
    prev_pix = p;
    if (x == w - 1) begin
      col_cnt = 0;
      up_line = mid_line;
      mid_line = cur_line;
      row_cnt = (y == h - 1) ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
      row_cnt = y;
    end
  endtask

  task automatic report_err(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_edges({in_blue, in_green, in_red});
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          {in_blue, in_green, in_red} <= pixel_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    edge_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (edge_q.size() == 0) begin
        report_err("edge word with nothing expected");
      end else begin
        e = edge_q.pop_front();
        if (out_direction !== e.dir)
          report_err($sformatf("direction %0b, want %0b", out_direction, e.dir));
        if (out_edge_column !== e.col)
          report_err($sformatf("column %0d, want %0d", out_edge_column, e.col));
        if (out_edge_row !== e.row)
          report_err($sformatf("row %0d, want %0d", out_edge_row, e.row));
        if (out_strength !== e.str)
          report_err($sformatf("strength %0d, want %0d", out_strength, e.str));
        if (out_last_of_run !== e.last)
          report_err($sformatf("last %0b, want %0b", out_last_of_run, e.last));
      end
    end
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DW-1:0];
    cfg_regs[idx] = (idx == REG_IMAGE_WIDTH) ? (val & 32'h7FF) :
                    (idx == REG_IMAGE_HEIGHT) ? (val & 32'hFFFF) : (val & 32'hFFF);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid || edge_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [23:0] gen_pixel(input int mode);
    logic [23:0] p;
    int v;
    p = 24'($urandom);
    if (mode == PIX_EXTREME) begin
      for (int c = 0; c < 3; c++) p[8*c +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    end else if (mode == PIX_SMOOTH) begin
      for (int c = 0; c < 3; c++) begin
        v = int'(last_gen[8*c +: 8]) + int'($urandom_range(8)) - 4;
        p[8*c +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
      end
    end
    last_gen = p;
    return p;
  endfunction

  task automatic push_pixels(input int unsigned n, input int mode);
    repeat (n) pixel_q.insert(pixel_q.size(), gen_pixel(mode));
  endtask

  task automatic finish_image();
    wait_idle();
    push_pixels(pixels_left(), PIX_RANDOM);
    wait_idle();
  endtask

  function automatic int unsigned rand_weight();
    case ($urandom_range(5))
      0: return 0;
      1: return 4095;
      2: return $urandom_range(4095);
      default: return $urandom_range(64, 512);
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    bit held;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(REG_IMAGE_WIDTH, 3);
    cfg_write(REG_IMAGE_HEIGHT, 3);
    pixel_q = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                24'hFFFFFF, 24'h000000, 24'h123456, 24'hFFFFFF};
    wait_idle();

    cfg_write(REG_IMAGE_WIDTH, 0);
    cfg_write(REG_IMAGE_HEIGHT, 0);
    cfg_write(REG_RED_WEIGHT, 4095);
    cfg_write(REG_GREEN_WEIGHT, 4095);
    cfg_write(REG_BLUE_WEIGHT, 4095);
    cfg_write(REG_ORTHO_WEIGHT, 4095);
    cfg_write(REG_MAIN_WEIGHT, 4095);
    pixel_q = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000};
    wait_idle();

    cfg_write(REG_ORTHO_WEIGHT, 0);
    cfg_write(REG_MAIN_WEIGHT, 256);
    cfg_write(REG_IMAGE_HEIGHT, 65535);
    push_pixels(4, PIX_EXTREME);
    wait_idle();
    cfg_write(REG_IMAGE_HEIGHT, 2);
    finish_image();

    cfg_write(REG_ORTHO_WEIGHT, 256);
    cfg_write(REG_IMAGE_WIDTH, 6);
    cfg_write(REG_IMAGE_HEIGHT, 3);
    push_pixels(9, PIX_RANDOM);
    wait_idle();
    cfg_write(REG_IMAGE_WIDTH, 4);
    finish_image();

    sent = 0;
    held = 0;
    while (sent < 340) begin
      if (sent < 113) begin
        send_idle_pct = 24; recv_idle_pct = 88;
      end else if (sent < 226) begin
        send_idle_pct = 88; recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      wait_idle();
      w = $urandom_range(2, 12);
      h = $urandom_range(1, 5);
      cfg_write(REG_IMAGE_WIDTH, w);
      cfg_write(REG_IMAGE_HEIGHT, h);
      cfg_write(REG_ORTHO_WEIGHT, rand_weight());
      cfg_write(REG_MAIN_WEIGHT, rand_weight());
      cfg_write(REG_RED_WEIGHT, rand_weight());
      cfg_write(REG_GREEN_WEIGHT, rand_weight());
      cfg_write(REG_BLUE_WEIGHT, rand_weight());
      if (!held && sent >= 260) begin
        @(negedge clk);
        rx_hold = 1500;
        held = 1;
      end
      push_pixels(w * h, $urandom_range(2));
      sent += w * h;
    end
    wait_idle();

    cfg_write(REG_IMAGE_WIDTH, 2047);
    cfg_write(REG_IMAGE_HEIGHT, 1);
    cfg_write(REG_MAIN_WEIGHT, 4095);
    push_pixels(30, PIX_RANDOM);
    wait_idle();
    cfg_write(REG_IMAGE_WIDTH, 16);
    finish_image();
    repeat (100) @(posedge clk);

    if (err_cnt == 0 && edge_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
